FILE: src/heading_hold_with_turn_sequence_assert.svh
// Assertion macros for the heading hold block
`ifndef HEADING_HOLD_WITH_TURN_SEQUENCE_ASSERT_SVH
`define HEADING_HOLD_WITH_TURN_SEQUENCE_ASSERT_SVH
`ifndef SYNTH
`define HHTS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("heading hold assertion failed");
`define HHTS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("heading hold assertion failed");
`else
`define HHTS_ASSERT(label, prop)
`define HHTS_ASSERT_NEXT(label, pre, post)
`endif
`endif

FILE: src/hhts_pkg.sv
// Types, codes and angle helpers for the heading hold block
package hhts_pkg;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  typedef enum logic [2:0] {
    KIND_START     = 3'd0,
    KIND_CONTROL   = 3'd1,
    KIND_TURN      = 3'd2,
    KIND_STOP      = 3'd3,
    KIND_RESET     = 3'd4,
    KIND_RECAPTURE = 3'd5
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FORWARD_SPEED = 3'd0,
    REG_GAIN_KP       = 3'd1,
    REG_DEADBAND      = 3'd2,
    REG_TURN_TOTAL    = 3'd3,
    REG_TURN_CW       = 3'd4,
    REG_TURN_ENABLE   = 3'd5
  } cfg_reg_t;

  localparam logic [1:0] END_NONE   = 2'd0;
  localparam logic [1:0] END_STOP   = 2'd1;
  localparam logic [1:0] END_SENSOR = 2'd2;

  localparam logic signed [15:0] FWD_RESET      = 16'sd16384;
  localparam logic signed [15:0] KP_RESET       = 16'sd1229;
  localparam logic [14:0]        DEADBAND_RESET = 15'd1000;
  localparam logic [7:0]         TURNS_RESET    = 8'd3;

  localparam logic signed [16:0] QUARTER_TURN = 17'sd9000;
  localparam logic signed [17:0] HALF_TURN    = 18'sd18000;
  localparam logic signed [17:0] FULL_TURN    = 18'sd36000;
  localparam logic signed [17:0] THREE_HALVES = 18'sd54000;
  localparam logic signed [17:0] TWO_TURNS    = 18'sd72000;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] heading;
    logic               sensor_enabled;
    logic               sensor_healthy;
  } in_t;

  typedef struct packed {
    logic signed [18:0] angular_speed;
    logic signed [15:0] forward_speed;
    logic               drive_valid;
    logic               is_running;
    logic               turns_finished;
    logic [1:0]         end_event;
  } out_t;

  // Bring any value within two turns of the origin into [-18000, 18000)
  function automatic logic signed [15:0] wrap_angle(input logic signed [16:0] v);
    logic signed [17:0] w;
    logic signed [17:0] r;
    begin
      w = {v[16], v};
      if (w >= THREE_HALVES) begin
        r = w - TWO_TURNS;
      end else if (w >= HALF_TURN) begin
        r = w - FULL_TURN;
      end else if (w < -THREE_HALVES) begin
        r = w + TWO_TURNS;
      end else if (w < -HALF_TURN) begin
        r = w + FULL_TURN;
      end else begin
        r = w;
      end
      return r[15:0];
    end
  endfunction

endpackage

FILE: src/heading_hold_with_turn_sequence.sv
// Heading hold regulator with timed turn sequence, top level
//
//  channel | direction | handshake             | payload
//  in      | request   | in_valid / in_ready   | in_data  (in_t)
//  out     | result    | out_valid / out_ready | out_data (out_t)
//  cfg     | write     | cfg_write             | cfg_index, cfg_data
//
// One request per cycle sustained; a request is registered in stage one, then its result in stage two:
// stage one updates the state and wraps the heading error, stage two runs the gain multiply.
// Synchronous reset clears control state and loads register defaults; no clearing pass.
// in_ready drops only while both stages hold results and out_ready is low.
module heading_hold_with_turn_sequence
  import hhts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_t                   out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

`include "heading_hold_with_turn_sequence_assert.svh"

  typedef struct packed {
    logic signed [15:0] err;
    logic               rate_on;
    logic               fwd_on;
    logic               drive_valid;
    logic               is_running;
    logic               turns_finished;
    logic [1:0]         end_event;
  } stage_t;

  // configuration
  logic signed [15:0] forward_speed_setting;
  logic signed [15:0] gain_kp;
  logic [14:0]        deadband;
  logic [7:0]         turn_total;
  logic               turn_clockwise;
  logic               turn_enable;

  // controller state
  logic               running, running_next;
  logic               finished_phase, finished_next;
  logic signed [15:0] target_heading, target_next;
  logic [7:0]         turns_left, turns_next;

  logic               accept;
  logic               s1_valid;
  logic               s1_advance;
  stage_t             s1;
  stage_t             s1_next;

  logic signed [15:0] err;
  logic [15:0]        err_mag;
  logic signed [15:0] turned_target;
  logic [7:0]         turns_load;
  logic [7:0]         turns_dec;

  logic signed [31:0] product;
  logic signed [18:0] rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      forward_speed_setting <= FWD_RESET;
      gain_kp               <= KP_RESET;
      deadband              <= DEADBAND_RESET;
      turn_total            <= TURNS_RESET;
      turn_clockwise        <= 1'b0;
      turn_enable           <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FORWARD_SPEED: forward_speed_setting <= cfg_data;
        REG_GAIN_KP:       gain_kp <= cfg_data;
        REG_DEADBAND:      deadband <= cfg_data[14:0];
        REG_TURN_TOTAL:    turn_total <= cfg_data[7:0];
        REG_TURN_CW:       turn_clockwise <= cfg_data[0];
        REG_TURN_ENABLE:   turn_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || !out_valid || out_ready;
  assign accept     = in_valid && in_ready;

  assign err = wrap_angle({target_heading[15], target_heading} -
                          {in_data.heading[15], in_data.heading});
  assign err_mag = err[15] ? 16'(-err) : 16'(err);
  assign turned_target = wrap_angle({target_heading[15], target_heading} +
                                    (turn_clockwise ? QUARTER_TURN : -QUARTER_TURN));
  // a turn count of zero acts as one
  assign turns_load = (turn_total == 8'd0) ? 8'd1 : turn_total;
  assign turns_dec  = turns_left - 8'd1;

  always_comb begin
    running_next  = running;
    finished_next = finished_phase;
    target_next   = target_heading;
    turns_next    = turns_left;
    s1_next       = '0;
    s1_next.err   = err;
    case (in_data.kind)
      KIND_START: begin
        if (!running) begin
          running_next  = 1'b1;
          finished_next = 1'b0;
          target_next   = in_data.heading;
          turns_next    = turns_load;
        end
      end
      KIND_CONTROL: begin
        if (running) begin
          s1_next.drive_valid = 1'b1;
          if (!in_data.sensor_enabled || !in_data.sensor_healthy) begin
            running_next      = 1'b0;
            s1_next.end_event = END_SENSOR;
          end else begin
            s1_next.fwd_on  = 1'b1;
            s1_next.rate_on = !(err_mag < {1'b0, deadband});
          end
        end
      end
      KIND_TURN: begin
        if (running && turns_left != 8'd0) begin
          if (turn_enable) begin
            target_next = turned_target;
          end
          turns_next = turns_dec;
          if (turns_dec == 8'd0) begin
            finished_next = 1'b1;
          end
        end
      end
      KIND_STOP: begin
        if (running) begin
          running_next        = 1'b0;
          s1_next.drive_valid = 1'b1;
          s1_next.end_event   = END_STOP;
        end
      end
      KIND_RESET: begin
        if (running) begin
          turns_next          = turns_load;
          finished_next       = 1'b0;
          s1_next.drive_valid = 1'b1;
          if (!in_data.sensor_enabled) begin
            running_next      = 1'b0;
            s1_next.end_event = END_STOP;
          end else if (!in_data.sensor_healthy) begin
            running_next      = 1'b0;
            s1_next.end_event = END_SENSOR;
          end else begin
            target_next = in_data.heading;
          end
        end
      end
      KIND_RECAPTURE: begin
        if (running && in_data.sensor_enabled) begin
          target_next = in_data.heading;
        end
      end
      default: ;
    endcase
    s1_next.is_running     = running_next;
    s1_next.turns_finished = finished_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running        <= 1'b0;
      finished_phase <= 1'b0;
      target_heading <= '0;
      turns_left     <= '0;
    end else if (accept) begin
      running        <= running_next;
      finished_phase <= finished_next;
      target_heading <= target_next;
      turns_left     <= turns_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

  // drop the Q4.12 fraction bits, flooring towards minus infinity
  assign product = gain_kp * s1.err;
  assign rate    = product[30:12];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data.angular_speed  <= s1.rate_on ? rate : '0;
      out_data.forward_speed  <= s1.fwd_on ? forward_speed_setting : '0;
      out_data.drive_valid    <= s1.drive_valid;
      out_data.is_running     <= s1.is_running;
      out_data.turns_finished <= s1.turns_finished;
      out_data.end_event      <= s1.end_event;
    end
  end

  `HHTS_ASSERT(a_turns_phase, !running || ((turns_left == 8'd0) == finished_phase))
  `HHTS_ASSERT(a_end_stops, !out_valid || out_data.end_event == END_NONE || !out_data.is_running)
  `HHTS_ASSERT(a_idle_zero, !out_valid || out_data.drive_valid || (out_data.angular_speed == '0 && out_data.forward_speed == '0 && out_data.end_event == END_NONE))
  `HHTS_ASSERT_NEXT(a_stage_hold, s1_valid && !s1_advance, s1_valid)

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the heading hold regulator with turn sequence
`timescale 1ns / 100ps

module tb_top;
  import hhts_pkg::*;

  // Kinds the block ignores
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  localparam int FULL_CD    = 36000;
  localparam int HALF_CD    = 18000;
  localparam int QUARTER_CD = 9000;
  localparam int GAIN_FRAC  = 12;
  localparam int MAX_WAIT   = 8;
  localparam int SETTLE     = 6;
  localparam int PHASES     = 8;
  localparam int PHASE_REQS = 100;

  class steering_scoreboard;
    logic signed [15:0] fwd_setting;
    logic signed [15:0] kp;
    logic [14:0]        deadband_cd;
    logic [7:0]         turn_count;
    logic               turn_cw;
    logic               turn_en;
    bit                 active;
    bit                 phase_done;
    logic signed [15:0] target;
    logic [7:0]         turns_remaining;
    out_t               expected_commands[$];
    int                 mismatches;

    function new();
      fwd_setting     = FWD_RESET;
      kp              = KP_RESET;
      deadband_cd     = DEADBAND_RESET;
      turn_count      = TURNS_RESET;
      turn_cw         = 1'b0;
      turn_en         = 1'b0;
      active          = 1'b0;
      phase_done      = 1'b0;
      target          = '0;
      turns_remaining = '0;
      mismatches      = 0;
    endfunction

    function void set_reg(input cfg_reg_t idx, input logic [15:0] val);
      case (idx)
        REG_FORWARD_SPEED: fwd_setting = val;
        REG_GAIN_KP:       kp = val;
        REG_DEADBAND:      deadband_cd = val[14:0];
        REG_TURN_TOTAL:    turn_count = val[7:0];
        REG_TURN_CW:       turn_cw = val[0];
        REG_TURN_ENABLE:   turn_en = val[0];
        default: ;
      endcase
    endfunction

    function int wrap_cd(input int v);
      int r;
      r = v % FULL_CD;
      if (r >= HALF_CD) r -= FULL_CD;
      if (r < -HALF_CD) r += FULL_CD;
      return r;
    endfunction

    function logic [7:0] load_turns();
      return (turn_count == 8'd0) ? 8'd1 : turn_count;
    endfunction

    function out_t predict_command(input in_t req);
      out_t   res;
      int     err;
      int     mag;
      longint rate;
      res = '0;
      if (req.kind == KIND_START) begin
        if (!active) begin
          phase_done      = 1'b0;
          target          = req.heading;
          turns_remaining = load_turns();
          active          = 1'b1;
        end
      end else if (active) begin
        case (req.kind)
          KIND_CONTROL: begin
            res.drive_valid = 1'b1;
            if (!req.sensor_enabled || !req.sensor_healthy) begin
              active        = 1'b0;
              res.end_event = END_SENSOR;
            end else begin
              err = wrap_cd(int'(target) - int'(req.heading));
              mag = (err < 0) ? -err : err;
              if (mag >= int'(deadband_cd)) begin
                // arithmetic shift floors towards minus infinity
                rate = (longint'(kp) * longint'(err)) >>> GAIN_FRAC;
                res.angular_speed = rate[18:0];
              end
              res.forward_speed = fwd_setting;
            end
          end
          KIND_TURN: begin
            if (turns_remaining != 8'd0) begin
              if (turn_en)
                target = 16'(wrap_cd(int'(target) + (turn_cw ? QUARTER_CD : -QUARTER_CD)));
              turns_remaining = turns_remaining - 8'd1;
              if (turns_remaining == 8'd0) phase_done = 1'b1;
            end
          end
          KIND_STOP: begin
            active          = 1'b0;
            res.drive_valid = 1'b1;
            res.end_event   = END_STOP;
          end
          KIND_RESET: begin
            turns_remaining = load_turns();
            phase_done      = 1'b0;
            res.drive_valid = 1'b1;
            if (req.sensor_enabled) begin
              if (req.sensor_healthy) begin
                target = req.heading;
              end else begin
                active        = 1'b0;
                res.end_event = END_SENSOR;
              end
            end else begin
              active        = 1'b0;
              res.end_event = END_STOP;
            end
          end
          KIND_RECAPTURE: begin
            if (req.sensor_enabled) target = req.heading;
          end
          default: ;
        endcase
      end
      res.is_running     = active;
      res.turns_finished = phase_done;
      return res;
    endfunction

    function void note_request(input in_t req);
      expected_commands.push_back(predict_command(req));
    endfunction

    function void compare(input string name, input logic signed [31:0] want,
                          input logic signed [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(input out_t got);
      out_t want;
      if (expected_commands.size() == 0) begin
        $error("result with nothing outstanding: %p", got);
        mismatches++;
        return;
      end
      want = expected_commands.pop_front();
      compare("angular_speed", want.angular_speed, got.angular_speed);
      compare("forward_speed", want.forward_speed, got.forward_speed);
      compare("drive_valid", want.drive_valid, got.drive_valid);
      compare("is_running", want.is_running, got.is_running);
      compare("turns_finished", want.turns_finished, got.turns_finished);
      compare("end_event", want.end_event, got.end_event);
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_t                    in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_t                   out_data;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  steering_scoreboard book = new();
  int in_calm = 0;
  int out_calm = 0;

  heading_hold_with_turn_sequence DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Random wait per item, with occasional runs of back-to-back traffic
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic in_t mk(input logic [2:0] kind, input logic signed [15:0] heading,
                             input logic en, input logic ok);
    in_t req;
    req.kind           = kind;
    req.heading        = heading;
    req.sensor_enabled = en;
    req.sensor_healthy = ok;
    return req;
  endfunction

  function automatic logic signed [15:0] draw_heading();
    int pick;
    pick = $urandom_range(0, 19);
    case (pick)
      0:       return -16'sd18000;
      1:       return 16'sd17999;
      2, 3:    return 16'($urandom);
      4, 5, 6: return 16'(int'(book.target) + $urandom_range(0, 4000) - 2000);
      default: return 16'($urandom_range(0, 35999) - 18000);
    endcase
  endfunction

  task automatic send_request(input in_t req);
    int gap;
    gap = draw_wait(in_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    book.note_request(req);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (book.expected_commands.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    book.set_reg(idx, val);
  endtask

  task automatic configure(input int phase);
    logic [15:0] vals [6];
    case (phase)
      0: vals = '{16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 16'h0001, 16'h0001};
      1: vals = '{16'h8000, 16'h8000, 16'd18000, 16'd255, 16'h0000, 16'h0001};
      2: vals = '{16'h0000, 16'h0001, 16'hffff, 16'h0001, 16'h0000, 16'h0000};
      3: vals = '{16'($urandom), 16'hffff, 16'h0000, 16'h0002, 16'hfffe, 16'h0001};
      default: begin
        vals[0] = 16'($urandom);
        vals[1] = 16'($urandom);
        vals[2] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
        vals[3] = 16'($urandom_range(0, 6));
        vals[4] = 16'($urandom);
        vals[5] = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'h0001;
      end
    endcase
    for (int i = 0; i < 6; i++) write_reg(cfg_reg_t'(i), vals[i]);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_directed();
    send_request(mk(KIND_CONTROL, 16'sd0, 1'b1, 1'b1));
    send_request(mk(KIND_SPARE_HI, 16'sd17999, 1'b1, 1'b1));
    send_request(mk(KIND_RESET, 16'sd0, 1'b1, 1'b1));
    // start ignores the sensor status
    send_request(mk(KIND_START, 16'sd17999, 1'b0, 1'b0));
    send_request(mk(KIND_START, -16'sd18000, 1'b1, 1'b1));
    send_request(mk(KIND_CONTROL, -16'sd18000, 1'b1, 1'b1));
    send_request(mk(KIND_CONTROL, 16'sd0, 1'b1, 1'b1));
    send_request(mk(KIND_CONTROL, -16'sd32768, 1'b1, 1'b1));
    send_request(mk(KIND_CONTROL, 16'sd32767, 1'b1, 1'b1));
    send_request(mk(KIND_RECAPTURE, -16'sd18000, 1'b0, 1'b1));
    send_request(mk(KIND_RECAPTURE, -16'sd18000, 1'b1, 1'b0));
    send_request(mk(KIND_CONTROL, 16'sd17999, 1'b1, 1'b1));
    repeat (4) send_request(mk(KIND_TURN, 16'sd0, 1'b1, 1'b1));
    send_request(mk(KIND_SPARE_LO, 16'sd0, 1'b1, 1'b1));
    send_request(mk(KIND_RESET, 16'sd100, 1'b1, 1'b1));
    send_request(mk(KIND_CONTROL, 16'sd100, 1'b0, 1'b1));
    send_request(mk(KIND_START, -16'sd32768, 1'b1, 1'b1));
    send_request(mk(KIND_RESET, 16'sd500, 1'b1, 1'b0));
    send_request(mk(KIND_START, 16'sd32767, 1'b1, 1'b1));
    send_request(mk(KIND_RESET, 16'sd500, 1'b0, 1'b1));
    send_request(mk(KIND_START, 16'sd0, 1'b1, 1'b1));
    send_request(mk(KIND_STOP, 16'sd0, 1'b1, 1'b1));
    send_request(mk(KIND_STOP, 16'sd0, 1'b1, 1'b1));
  endtask

  // Mostly well-formed runs: start, then ticks, turns, recaptures and resets, ending in stop or fault
  task automatic run_random(input int count);
    int   done;
    int   pick;
    bit   counts;
    in_t  req;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (!book.active && pick < 85)
        req = mk(KIND_START, draw_heading(), 1'($urandom), 1'($urandom));
      else if (pick < 45)
        req = mk(KIND_CONTROL, draw_heading(), 1'b1, 1'b1);
      else if (pick < 49)
        req = mk(KIND_CONTROL, draw_heading(), 1'($urandom), 1'($urandom));
      else if (pick < 67)
        req = mk(KIND_TURN, draw_heading(), 1'($urandom), 1'($urandom));
      else if (pick < 75)
        req = mk(KIND_RECAPTURE, draw_heading(), $urandom_range(0, 3) != 0, 1'($urandom));
      else if (pick < 82)
        req = mk(KIND_RESET, draw_heading(), $urandom_range(0, 3) != 0,
                 $urandom_range(0, 3) != 0);
      else if (pick < 86)
        req = mk(KIND_STOP, draw_heading(), 1'($urandom), 1'($urandom));
      else
        req = mk(3'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
      counts = (req.kind == KIND_START) ? !book.active
                                        : (book.active && req.kind <= KIND_RECAPTURE);
      send_request(req);
      if (counts) done++;
    end
  endtask

  initial begin : result_sink
    int stall;
    wait (!rst);
    @(posedge clk);
    forever begin
      stall = draw_wait(out_calm);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      book.check_result(out_data);
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    wait_idle();
    for (int phase = 0; phase < PHASES; phase++) begin
      configure(phase);
      run_random(PHASE_REQS);
      wait_idle();
    end
    if (book.mismatches == 0 && book.expected_commands.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
